FILE: rtl/msl_pkg.sv
// shared widths, codes, register defaults and neighbour offset tables for the mat lattice unit
package msl_pkg;

   localparam int SideDefault     = 256;
   localparam int ProbBitsDefault = 16;

   localparam int FuncW    = 2;
   localparam int CoordW   = 8;
   localparam int ProbW    = 16;
   localparam int DirW     = 3;
   localparam int CauseW   = 2;
   localparam int TotalW   = 17;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int DirN     = 8;

   typedef enum logic [FuncW-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_UPDATE = 2'd1,
      FUNC_BEGIN  = 2'd2
   } func_type;

   typedef enum logic [CauseW-1:0] {
      CAUSE_NONE       = 2'd0,
      CAUSE_GOATFISH   = 2'd1,
      CAUSE_FISH       = 2'd2,
      CAUSE_SENESCENCE = 2'd3
   } cause_type;

   typedef enum logic [CsrIdxW-1:0] {
      REG_DISPERSAL  = 3'd0,
      REG_GROWTH     = 3'd1,
      REG_GOATFISH   = 3'd2,
      REG_FISH       = 3'd3,
      REG_SENESCENCE = 3'd4
   } reg_index_type;

   localparam logic [ProbW-1:0] DispersalReset  = 16'd66;
   localparam logic [ProbW-1:0] GrowthReset     = 16'd32768;
   localparam logic [ProbW-1:0] GoatfishReset   = 16'd13763;
   localparam logic [ProbW-1:0] FishReset       = 16'd18350;
   localparam logic [ProbW-1:0] SenescenceReset = 16'd13763;

   typedef enum logic [1:0] {
      STEP_DEC,
      STEP_KEEP,
      STEP_INC
   } step_type;

   localparam step_type RowStep [DirN] = '{
      STEP_DEC, STEP_KEEP, STEP_INC, STEP_DEC, STEP_INC, STEP_DEC, STEP_KEEP, STEP_INC
   };
   localparam step_type ColStep [DirN] = '{
      STEP_DEC, STEP_DEC, STEP_DEC, STEP_KEEP, STEP_KEEP, STEP_INC, STEP_INC, STEP_INC
   };

   typedef struct packed {
      logic capture;
      logic exec;
      logic commit;
      logic clear_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

FILE: rtl/msl_chan_if.sv
// request and response channel interfaces of the mat lattice unit
interface msl_req_if import msl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FuncW-1:0]    func;
   logic [CoordW-1:0]   row;
   logic [CoordW-1:0]   col;
   logic                load_value;
   logic [ProbW-1:0]    disp_draw;
   logic [DirW-1:0]     direction;
   logic [ProbW-1:0]    growth_draw;
   logic [ProbW-1:0]    goat_draw;
   logic [ProbW-1:0]    fish_draw;
   logic [ProbW-1:0]    senes_draw;

   modport source (
      output valid, func, row, col, load_value, disp_draw, direction,
             growth_draw, goat_draw, fish_draw, senes_draw,
      input  ready
   );
   modport sink (
      input  valid, func, row, col, load_value, disp_draw, direction,
             growth_draw, goat_draw, fish_draw, senes_draw,
      output ready
   );
endinterface

interface msl_rsp_if import msl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                focal_state;
   logic                colonized;
   logic                neighbour_grown;
   logic [CauseW-1:0]   disturb_cause;
   logic [TotalW-1:0]   mat_total;
   logic [TotalW-1:0]   sediment_total;

   modport source (
      output valid, focal_state, colonized, neighbour_grown, disturb_cause,
             mat_total, sediment_total,
      input  ready
   );
   modport sink (
      input  valid, focal_state, colonized, neighbour_grown, disturb_cause,
             mat_total, sediment_total,
      output ready
   );
endinterface

FILE: rtl/msl_ctrl.sv
// sequencing state machine: grid clearing pass, capture, execute and commit steps
module msl_ctrl import msl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cmd.capture    = (state_ff == ST_IDLE) && req_ready_ff && req_valid;
   assign cmd.exec       = (state_ff == ST_EXEC);
   assign cmd.commit     = (state_ff == ST_COMMIT) && slot_free;
   assign cmd.clear_step = (state_ff == ST_CLEAR);

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff     <= ST_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (slot_free) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_CLEAR;
               req_ready_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

FILE: rtl/msl_dpath.sv
// datapath: grid memory, counts, probability registers, event decisions and result register
module msl_dpath import msl_pkg::*; #(
   parameter int SIDE      = SideDefault,
   parameter int PROB_BITS = ProbBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   input  logic [FuncW-1:0]    req_func,
   input  logic [CoordW-1:0]   req_row,
   input  logic [CoordW-1:0]   req_col,
   input  logic                req_load_value,
   input  logic [ProbW-1:0]    req_disp_draw,
   input  logic [DirW-1:0]     req_direction,
   input  logic [ProbW-1:0]    req_growth_draw,
   input  logic [ProbW-1:0]    req_goat_draw,
   input  logic [ProbW-1:0]    req_fish_draw,
   input  logic [ProbW-1:0]    req_senes_draw,
   output logic                rsp_focal_state,
   output logic                rsp_colonized,
   output logic                rsp_neighbour_grown,
   output logic [CauseW-1:0]   rsp_disturb_cause,
   output logic [TotalW-1:0]   rsp_mat_total,
   output logic [TotalW-1:0]   rsp_sediment_total
);

   localparam int CellN = SIDE * SIDE;
   localparam int AddrW = $clog2(CellN);
   localparam int PosW  = $clog2(SIDE);
   localparam int CntW  = $clog2(CellN + 1);
   localparam int CmpW  = (PROB_BITS < ProbW) ? PROB_BITS : ProbW;

   function automatic logic [PosW-1:0] wrap_step(input logic [PosW-1:0] p, input step_type s);
      logic [PosW-1:0] r;
      r = p;
      case (s)
         STEP_DEC: r = (p == '0) ? PosW'(SIDE - 1) : p - 1'b1;
         STEP_INC: r = (p == PosW'(SIDE - 1)) ? '0 : p + 1'b1;
         default:  r = p;
      endcase
      return r;
   endfunction

   function automatic logic fires(input logic [CmpW-1:0] draw, input logic [ProbW-1:0] prob);
      return draw < prob[CmpW-1:0];
   endfunction

   logic grid [CellN];

   logic [ProbW-1:0]  disp_prob_ff, growth_prob_ff, goat_prob_ff, fish_prob_ff, senes_prob_ff;
   logic [AddrW-1:0]  clr_addr_ff;
   logic [CntW-1:0]   mat_ff, mat_in;
   logic [CntW-1:0]   sed_ff, sed_in;
   logic              latch_ff;

   logic [FuncW-1:0]  func_ff;
   logic              in_range_ff;
   logic              load_ff;
   logic [CmpW-1:0]   disp_ff, growth_ff, goat_ff, fish_ff, senes_ff;
   logic [AddrW-1:0]  focal_addr_ff, nbr_addr_ff;
   logic              focal_bit_ff, nbr_bit_ff;
   logic              colon_ff, grown_ff;
   logic [CauseW-1:0] cause_ff;

   logic              focal_out_ff, colon_out_ff, grown_out_ff;
   logic [CauseW-1:0] cause_out_ff;
   logic [TotalW-1:0] mat_out_ff, sed_out_ff;

   logic [PosW-1:0]   row_pos, col_pos, nbr_row, nbr_col;
   logic [AddrW-1:0]  focal_addr_c, nbr_addr_c;
   logic              in_range_c;
   logic              is_update, colon_c, grow_c, focal_new, focal_chg, grid_we, grid_wd;
   logic [CauseW-1:0] cause_c;
   logic [AddrW-1:0]  grid_wa;

   // address generation from the incoming transaction
   assign row_pos      = PosW'(req_row);
   assign col_pos      = PosW'(req_col);
   assign in_range_c   = (int'(req_row) < SIDE) && (int'(req_col) < SIDE);
   assign nbr_row      = wrap_step(row_pos, RowStep[req_direction]);
   assign nbr_col      = wrap_step(col_pos, ColStep[req_direction]);
   assign focal_addr_c = AddrW'(int'(row_pos) * SIDE + int'(col_pos));
   assign nbr_addr_c   = AddrW'(int'(nbr_row) * SIDE + int'(nbr_col));

   // event decisions on the cells read at capture
   assign is_update = in_range_ff && (func_ff == FUNC_UPDATE);
   assign colon_c   = is_update && !focal_bit_ff && latch_ff && fires(disp_ff, disp_prob_ff);
   assign grow_c    = is_update && focal_bit_ff && !nbr_bit_ff && fires(growth_ff, growth_prob_ff);

   always_comb begin
      cause_c = CAUSE_NONE;
      if (is_update && focal_bit_ff) begin
         if (fires(goat_ff, goat_prob_ff)) begin
            cause_c = CAUSE_GOATFISH;
         end else if (fires(fish_ff, fish_prob_ff)) begin
            cause_c = CAUSE_FISH;
         end else if (fires(senes_ff, senes_prob_ff)) begin
            cause_c = CAUSE_SENESCENCE;
         end
      end
   end

   always_comb begin
      focal_new = focal_bit_ff;
      if (func_ff == FUNC_LOAD) begin
         focal_new = load_ff;
      end else if (func_ff == FUNC_UPDATE) begin
         if (colon_ff) begin
            focal_new = 1'b1;
         end else if (cause_ff != CAUSE_NONE) begin
            focal_new = 1'b0;
         end
      end
   end

   assign focal_chg = in_range_ff && (focal_new != focal_bit_ff);

   always_comb begin
      mat_in = mat_ff;
      sed_in = sed_ff;
      if ((cmd.exec && grow_c) || (cmd.commit && focal_chg && focal_new)) begin
         mat_in = mat_ff + 1'b1;
         if (sed_ff != '0) begin
            sed_in = sed_ff - 1'b1;
         end
      end else if (cmd.commit && focal_chg) begin
         sed_in = sed_ff + 1'b1;
         if (mat_ff != '0) begin
            mat_in = mat_ff - 1'b1;
         end
      end
   end

   always_comb begin
      grid_we = 1'b0;
      grid_wa = focal_addr_ff;
      grid_wd = focal_new;
      if (cmd.clear_step) begin
         grid_we = 1'b1;
         grid_wa = clr_addr_ff;
         grid_wd = 1'b0;
      end else if (cmd.exec) begin
         grid_we = grow_c;
         grid_wa = nbr_addr_ff;
         grid_wd = 1'b1;
      end else if (cmd.commit) begin
         grid_we = focal_chg;
      end
   end

   assign status.clear_last = (clr_addr_ff == AddrW'(CellN - 1));

   // grid memory
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid[grid_wa] <= grid_wd;
      end
      if (cmd.capture) begin
         focal_bit_ff <= grid[focal_addr_c];
         nbr_bit_ff   <= grid[nbr_addr_c];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_prob_ff   <= DispersalReset;
         growth_prob_ff <= GrowthReset;
         goat_prob_ff   <= GoatfishReset;
         fish_prob_ff   <= FishReset;
         senes_prob_ff  <= SenescenceReset;
         clr_addr_ff    <= '0;
         mat_ff         <= '0;
         sed_ff         <= CntW'(CellN);
         latch_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_DISPERSAL:  disp_prob_ff   <= csr_data;
               REG_GROWTH:     growth_prob_ff <= csr_data;
               REG_GOATFISH:   goat_prob_ff   <= csr_data;
               REG_FISH:       fish_prob_ff   <= csr_data;
               REG_SENESCENCE: senes_prob_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         mat_ff <= mat_in;
         sed_ff <= sed_in;
         if (cmd.commit && (func_ff == FUNC_BEGIN)) begin
            latch_ff <= (mat_ff != '0);
         end
      end
   end

   // transaction payload, decisions and result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff       <= req_func;
         in_range_ff   <= in_range_c;
         load_ff       <= req_load_value;
         disp_ff       <= req_disp_draw[CmpW-1:0];
         growth_ff     <= req_growth_draw[CmpW-1:0];
         goat_ff       <= req_goat_draw[CmpW-1:0];
         fish_ff       <= req_fish_draw[CmpW-1:0];
         senes_ff      <= req_senes_draw[CmpW-1:0];
         focal_addr_ff <= focal_addr_c;
         nbr_addr_ff   <= nbr_addr_c;
      end
      if (cmd.exec) begin
         colon_ff <= colon_c;
         grown_ff <= grow_c;
         cause_ff <= cause_c;
      end
      if (cmd.commit) begin
         focal_out_ff <= in_range_ff && focal_new;
         colon_out_ff <= colon_ff;
         grown_out_ff <= grown_ff;
         cause_out_ff <= cause_ff;
         mat_out_ff   <= TotalW'(mat_in);
         sed_out_ff   <= TotalW'(sed_in);
      end
   end

   assign rsp_focal_state     = focal_out_ff;
   assign rsp_colonized       = colon_out_ff;
   assign rsp_neighbour_grown = grown_out_ff;
   assign rsp_disturb_cause   = cause_out_ff;
   assign rsp_mat_total       = mat_out_ff;
   assign rsp_sediment_total  = sed_out_ff;

endmodule

FILE: rtl/stochastic_mat_lattice_step_unit.sv
// top level of the mat lattice unit: controller, datapath and channel hookup
//
// Usage:
//  req_chan carries one transaction per command: load a cell, update a cell or
//  begin a pass, together with the coordinates, load value and random draws.
//  rsp_chan returns exactly one result per request: the addressed cell after
//  the command, the event flags, the disturbance cause and both running totals.
//  csr_wr_en/csr_index/csr_data write the five probability registers; the user
//  must do so only while no request is in flight; the block does not enforce it.
//  A request moves through the capture, execute and commit states, and its
//  result is registered at commit. A new request is taken only once the last
//  has committed; the grid memory has one write port, and an update may write
//  both the neighbour and the focal cell. After reset the grid is swept to
//  sediment, one cell per cycle, over all SIDE*SIDE cells (65536 at the default
//  size) with req_chan.ready low; registers and counts reset at once.
//  A held result sits in the output register: the next request is still taken,
//  and its commit waits until rsp_chan.ready frees the register.
module stochastic_mat_lattice_step_unit import msl_pkg::*; #(
   parameter int SIDE      = SideDefault,
   parameter int PROB_BITS = ProbBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   msl_req_if.sink             req_chan,
   msl_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   localparam int CellN = SIDE * SIDE;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   msl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msl_dpath #(
      .SIDE      (SIDE),
      .PROB_BITS (PROB_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_func            (req_chan.func),
      .req_row             (req_chan.row),
      .req_col             (req_chan.col),
      .req_load_value      (req_chan.load_value),
      .req_disp_draw       (req_chan.disp_draw),
      .req_direction       (req_chan.direction),
      .req_growth_draw     (req_chan.growth_draw),
      .req_goat_draw       (req_chan.goat_draw),
      .req_fish_draw       (req_chan.fish_draw),
      .req_senes_draw      (req_chan.senes_draw),
      .rsp_focal_state     (rsp_chan.focal_state),
      .rsp_colonized       (rsp_chan.colonized),
      .rsp_neighbour_grown (rsp_chan.neighbour_grown),
      .rsp_disturb_cause   (rsp_chan.disturb_cause),
      .rsp_mat_total       (rsp_chan.mat_total),
      .rsp_sediment_total  (rsp_chan.sediment_total)
   );

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_chan.valid)
      else $error("commit did not present a result");

   a_totals_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         TotalW'(rsp_chan.mat_total + rsp_chan.sediment_total) == TotalW'(CellN))
      else $error("mat and sediment totals do not cover the grid");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_chan.ready && cmd.exec)
      else $error("request taken while another is in flight");

   a_no_capture_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !cmd.capture && !cmd.commit)
      else $error("transaction activity during grid clearing");

endmodule
